@@ src/sba_pkg.sv @@
// Package for the size-class block allocator: field widths, codes, payload structs,
// the size-class table and the size-to-class mapping. No dependencies.
package sba_pkg;

    localparam int ADDR_W          = 20;
    localparam int SIZE_W          = 12;
    localparam int GRAN_W          = 16;
    localparam int LINK_W          = GRAN_W + 1;
    localparam int SUM_W           = ADDR_W + 1;
    localparam int NUM_CLASSES     = 14;
    localparam int CLS_W           = 4;
    localparam int BS_W            = 10;
    localparam int MAX_BLOCK       = 640;
    localparam int NUM_CHUNKS_DEF  = 64;
    localparam int CHUNK_BYTES_DEF = 16384;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_RSVD  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_IGNORED   = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_NO_MEMORY = 2'd3
    } status_t;

    typedef struct packed {
        func_t              func;
        logic [SIZE_W-1:0]  req_size;
        logic [ADDR_W-1:0]  block_addr;
        logic               addr_valid;
    } sba_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  grant_addr;
        status_t            status;
    } sba_rsp_t;

    // One write to the link memory.
    typedef struct packed {
        logic               we;
        logic [GRAN_W-1:0]  addr;
        logic [LINK_W-1:0]  data;
    } sba_link_wr_t;

    localparam logic [BS_W-1:0] CLASS_BYTES [NUM_CLASSES] = '{
        10'd16, 10'd32, 10'd64, 10'd96, 10'd128, 10'd160, 10'd192,
        10'd224, 10'd256, 10'd320, 10'd384, 10'd448, 10'd512, 10'd640
    };

    // The thresholds rise monotonically, so the class is the number of them the size exceeds.
    function automatic logic [CLS_W-1:0] size_class(input logic [SIZE_W-1:0] size);
        logic [CLS_W-1:0] cls;
        cls = '0;
        for (int i = 0; i < NUM_CLASSES - 1; i++) begin
            if (size > SIZE_W'(CLASS_BYTES[i])) begin
                cls = cls + CLS_W'(1);
            end
        end
        return cls;
    endfunction

endpackage

@@ src/sba_link_ram.sv @@
// Free-list link memory: one 17-bit entry per 16-byte granule of the address space.
// Depends on sba_pkg.
module sba_link_ram
    import sba_pkg::*;
(
    input  logic               aclk,
    input  sba_link_wr_t       wr,
    input  logic               rd_en,
    input  logic [GRAN_W-1:0]  rd_addr,
    output logic [LINK_W-1:0]  rd_data
);

    logic [LINK_W-1:0] mem [2**GRAN_W];

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/sba_addr_unit.sv @@
// Shared address adder with a bound compare, used by the sequencer for every address step.
// Depends on sba_pkg.
module sba_addr_unit
    import sba_pkg::*;
(
    input  logic [SUM_W-1:0] op_a,
    input  logic [SUM_W-1:0] op_b,
    input  logic [SUM_W-1:0] limit,
    output logic [SUM_W-1:0] sum,
    output logic             fits
);

    assign sum  = op_a + op_b;
    assign fits = (sum <= limit);

endmodule

@@ src/size_class_block_allocator.sv @@
// Size-class block allocator top level: sequencer, class heads and chunk bookkeeping.
// Depends on sba_pkg, sba_addr_unit and sba_link_ram.
//
// This block serves allocate, free and clear transactions for a pool of NUM_CHUNKS chunks
// of CHUNK_BYTES bytes, handing out blocks of fourteen size classes from 16 to 640 bytes.
// It handles one transaction at a time and drops s_ready while it works. A free, a clear
// or any rejected request passes from the decode state to the response state, which loads
// the output register. An allocate served from a class list passes through a pop state
// between the two, because the next-link of the popped block is read from the link memory.
// An allocate that finds its class list empty carves a new chunk: the link memory has one
// write port, so the walk writes one link per cycle, one block of the class after another,
// and a finish state then books the chunk. The link memory needs no clearing after reset,
// so the block is ready right away. The result register lets a new transaction be accepted
// while the previous result still waits for m_ready; the result after that one then waits
// in the sequencer, with s_ready low, until the register drains.
module size_class_block_allocator
    import sba_pkg::*;
#(
    parameter int NUM_CHUNKS  = NUM_CHUNKS_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sba_req_t s_req,
    output logic     m_valid,
    input  logic     m_ready,
    output sba_rsp_t m_rsp
);

    localparam int CU_W = $clog2(NUM_CHUNKS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_CARVE,
        S_FINISH,
        S_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    sba_rsp_t              m_rsp_reg, m_rsp_next;
    logic [NUM_CLASSES-1:0] head_valid_reg;
    logic [CU_W-1:0]       chunks_reg, chunks_next;
    logic [SUM_W-1:0]      base_reg, base_next;
    logic [SUM_W-1:0]      end_reg, end_next;
    logic                  first_reg, first_next;

    // Transaction and walk registers; these carry data only and need no reset.
    func_t                 func_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [GRAN_W-1:0]     gran_reg;
    logic                  avalid_reg;
    logic [CLS_W-1:0]      class_reg;
    logic [GRAN_W-1:0]     head_gran_reg [NUM_CLASSES];
    logic [SUM_W-1:0]      cur_reg, cur_next;
    logic [SUM_W-1:0]      nxt_reg, nxt_next;
    sba_rsp_t              rsp_reg, rsp_next;

    logic                  accept;
    logic                  clear_all;
    logic                  head_we;
    logic                  head_wvalid;
    logic [GRAN_W-1:0]     head_wgran;
    logic                  cur_head_valid;
    logic [GRAN_W-1:0]     cur_head_gran;
    logic [SUM_W-1:0]      block_bytes;

    sba_link_wr_t          link_wr;
    logic                  link_rd_en;
    logic [GRAN_W-1:0]     link_rd_addr;
    logic [LINK_W-1:0]     link_rd_data;

    logic [SUM_W-1:0]      unit_a, unit_b, unit_limit, unit_sum;
    logic                  unit_fits;

    sba_addr_unit u_addr_unit (
        .op_a  (unit_a),
        .op_b  (unit_b),
        .limit (unit_limit),
        .sum   (unit_sum),
        .fits  (unit_fits)
    );

    sba_link_ram u_link_ram (
        .aclk    (aclk),
        .wr      (link_wr),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    assign cur_head_valid = head_valid_reg[class_reg];
    assign cur_head_gran  = head_gran_reg[class_reg];
    assign block_bytes    = SUM_W'(CLASS_BYTES[class_reg]);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_rsp_next   = m_rsp_reg;
        chunks_next  = chunks_reg;
        base_next    = base_reg;
        end_next     = end_reg;
        first_next   = first_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        rsp_next     = rsp_reg;
        clear_all    = 1'b0;
        head_we      = 1'b0;
        head_wvalid  = 1'b0;
        head_wgran   = '0;
        link_wr      = '0;
        link_rd_en   = 1'b0;
        link_rd_addr = cur_head_gran;
        unit_a       = '0;
        unit_b       = '0;
        unit_limit   = end_reg;

        // The result register drains independently of the sequencer.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE: begin
                rsp_next   = '{grant_addr: '0, status: ST_IGNORED};
                state_next = S_RESP;
                case (func_reg)
                    FUNC_CLEAR: begin
                        clear_all   = 1'b1;
                        chunks_next = '0;
                        base_next   = '0;
                        end_next    = SUM_W'(CHUNK_BYTES);
                        rsp_next    = '{grant_addr: '0, status: ST_OK};
                    end
                    FUNC_FREE: begin
                        if (size_reg == '0 || !avalid_reg) begin
                            rsp_next.status = ST_IGNORED;
                        end else if (size_reg > SIZE_W'(MAX_BLOCK)) begin
                            rsp_next.status = ST_TOO_LARGE;
                        end else begin
                            // Push: the freed block points at the old head.
                            link_wr.we   = 1'b1;
                            link_wr.addr = gran_reg;
                            link_wr.data = cur_head_valid ? {1'b1, cur_head_gran} : '0;
                            head_we      = 1'b1;
                            head_wvalid  = 1'b1;
                            head_wgran   = gran_reg;
                            rsp_next.status = ST_OK;
                        end
                    end
                    FUNC_ALLOC: begin
                        if (size_reg == '0) begin
                            rsp_next.status = ST_IGNORED;
                        end else if (size_reg > SIZE_W'(MAX_BLOCK)) begin
                            rsp_next.status = ST_TOO_LARGE;
                        end else if (cur_head_valid) begin
                            // Pop: fetch the head's link, the new head arrives next cycle.
                            link_rd_en = 1'b1;
                            rsp_next   = '{grant_addr: {cur_head_gran, 4'b0000},
                                           status: ST_OK};
                            state_next = S_POP;
                        end else if (chunks_reg == CU_W'(NUM_CHUNKS)) begin
                            rsp_next.status = ST_NO_MEMORY;
                        end else begin
                            // Start carving the next chunk at its base.
                            unit_a     = base_reg;
                            unit_b     = block_bytes;
                            cur_next   = base_reg;
                            nxt_next   = unit_sum;
                            first_next = 1'b1;
                            rsp_next   = '{grant_addr: base_reg[ADDR_W-1:0], status: ST_OK};
                            state_next = S_CARVE;
                        end
                    end
                    default: begin
                        rsp_next.status = ST_IGNORED;
                    end
                endcase
            end

            S_POP: begin
                head_we     = 1'b1;
                head_wvalid = link_rd_data[GRAN_W];
                head_wgran  = link_rd_data[GRAN_W-1:0];
                state_next  = S_RESP;
            end

            S_CARVE: begin
                // The unit checks whether the block at nxt still fits in the chunk.
                unit_a       = nxt_reg;
                unit_b       = block_bytes;
                link_wr.we   = 1'b1;
                link_wr.addr = cur_reg[ADDR_W-1:4];
                first_next   = 1'b0;
                if (first_reg) begin
                    head_we     = 1'b1;
                    head_wvalid = unit_fits;
                    head_wgran  = nxt_reg[ADDR_W-1:4];
                end
                if (unit_fits) begin
                    link_wr.data = {1'b1, nxt_reg[ADDR_W-1:4]};
                    cur_next     = nxt_reg;
                    nxt_next     = unit_sum;
                end else begin
                    // The block at cur is the last one; it ends the list.
                    link_wr.data = '0;
                    state_next   = S_FINISH;
                end
            end

            S_FINISH: begin
                unit_a      = end_reg;
                unit_b      = SUM_W'(CHUNK_BYTES);
                chunks_next = chunks_reg + CU_W'(1);
                base_next   = end_reg;
                end_next    = unit_sum;
                state_next  = S_RESP;
            end

            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rsp_next   = rsp_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Note that the carve in the last state of the walk writes the list end for cur, which
    // at that point is the last block of the chunk.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            head_valid_reg <= '0;
            chunks_reg     <= '0;
            base_reg       <= '0;
            end_reg        <= SUM_W'(CHUNK_BYTES);
            first_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            m_rsp_reg   <= m_rsp_next;
            chunks_reg  <= chunks_next;
            base_reg    <= base_next;
            end_reg     <= end_next;
            first_reg   <= first_next;
            if (clear_all) begin
                head_valid_reg <= '0;
            end else if (head_we) begin
                head_valid_reg[class_reg] <= head_wvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg   <= s_req.func;
            size_reg   <= s_req.req_size;
            gran_reg   <= s_req.block_addr[ADDR_W-1:4];
            avalid_reg <= s_req.addr_valid;
            class_reg  <= size_class(s_req.req_size);
        end
        if (head_we) begin
            head_gran_reg[class_reg] <= head_wgran;
        end
        cur_reg <= cur_next;
        nxt_reg <= nxt_next;
        rsp_reg <= rsp_next;
    end

endmodule

@@ sim/size_class_block_allocator_tb.sv @@
// Self-checking testbench for size_class_block_allocator: directed table, pool exhaustion
// and random traffic, scored against typed answers or a predictor kept in this file. Depends on sba_pkg.
module size_class_block_allocator_tb;
    import sba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The block is tested at its default geometry: 64 chunks of 16 KiB.
    localparam int NUM_CHUNKS   = NUM_CHUNKS_DEF;
    localparam int CHUNK_BYTES  = CHUNK_BYTES_DEF;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 400;
    // The limit lies well above what a correct run needs, even if every allocate had to carve a
    // chunk for 16-byte blocks and every transaction waited out the longest gap on both sides.
    localparam int CYCLE_LIMIT  = 5_000_000;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    sba_req_t s_req;
    logic     m_valid;
    logic     m_ready;
    sba_rsp_t m_rsp;

    size_class_block_allocator #(
        .NUM_CHUNKS  (NUM_CHUNKS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // One row of the directed table. Where the answer is obvious it is typed in; otherwise
    // the predictor supplies it.
    typedef struct {
        sba_req_t req;
        bit       typed;
        sba_rsp_t rsp;
    } stim_row_t;

    // A block that has been granted and not yet handed back, with the class it came from.
    typedef struct {
        logic [ADDR_W-1:0] addr;
        int                cls;
    } held_block_t;

    // Predicted allocator state: the head of every class list (valid bit on top), one link
    // per 16-byte granule, and the number of chunks carved so far.
    logic [ADDR_W:0]   free_head [NUM_CLASSES];
    logic [LINK_W-1:0] granule_link [1 << GRAN_W];
    int unsigned       carved_chunks;

    sba_rsp_t    due_rsp[$];
    held_block_t held_blocks[$];
    stim_row_t   directed_rows[$];

    int unsigned cycle_count = 0;
    int unsigned rsp_count   = 0;
    int unsigned errors      = 0;
    int          quiet_left  = 0;
    bit          hold_off_req = 1'b0;
    sba_rsp_t    rsp_want;

    task automatic report_mismatch(input string msg);
        $display("[cycle %0d] mismatch on result %0d: %s", cycle_count, rsp_count, msg);
        errors++;
    endtask

    // Smallest class whose block holds the size; anything above the largest maps to it.
    function automatic int class_of(input logic [SIZE_W-1:0] size);
        int c;
        c = 0;
        while (c < NUM_CLASSES - 1 && size > CLASS_BYTES[c]) begin
            c++;
        end
        return c;
    endfunction

    // Applies one transaction to the predicted state and returns the result it must give.
    function automatic sba_rsp_t serve_request(input sba_req_t r);
        sba_rsp_t          rsp;
        int                cls;
        logic [GRAN_W-1:0] gran;
        logic [ADDR_W-1:0] top;
        logic [LINK_W-1:0] link;
        int unsigned       base;
        int unsigned       bs;
        int unsigned       count;
        rsp.grant_addr = '0;
        rsp.status     = ST_IGNORED;
        cls = class_of(r.req_size);
        case (r.func)
            FUNC_CLEAR: begin
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    free_head[c] = '0;
                end
                carved_chunks = 0;
                rsp.status = ST_OK;
            end
            FUNC_FREE: begin
                if (r.req_size == 0 || !r.addr_valid) begin
                    rsp.status = ST_IGNORED;
                end else if (r.req_size > MAX_BLOCK) begin
                    rsp.status = ST_TOO_LARGE;
                end else begin
                    gran = r.block_addr[ADDR_W-1:4];
                    if (free_head[cls][ADDR_W]) begin
                        granule_link[gran] = {1'b1, free_head[cls][ADDR_W-1:4]};
                    end else begin
                        granule_link[gran] = '0;
                    end
                    free_head[cls] = {1'b1, gran, 4'b0000};
                    rsp.status = ST_OK;
                end
            end
            FUNC_ALLOC: begin
                if (r.req_size == 0) begin
                    rsp.status = ST_IGNORED;
                end else if (r.req_size > MAX_BLOCK) begin
                    rsp.status = ST_TOO_LARGE;
                end else if (free_head[cls][ADDR_W]) begin
                    top  = free_head[cls][ADDR_W-1:0];
                    link = granule_link[top[ADDR_W-1:4]];
                    if (link[GRAN_W]) begin
                        free_head[cls] = {1'b1, link[GRAN_W-1:0], 4'b0000};
                    end else begin
                        free_head[cls] = '0;
                    end
                    rsp.grant_addr = top;
                    rsp.status     = ST_OK;
                end else if (carved_chunks >= NUM_CHUNKS) begin
                    rsp.status = ST_NO_MEMORY;
                end else begin
                    bs    = 32'(CLASS_BYTES[cls]);
                    base  = (carved_chunks * CHUNK_BYTES) & ((1 << ADDR_W) - 1);
                    count = CHUNK_BYTES / bs;
                    for (int i = 0; i + 1 < count; i++) begin
                        granule_link[GRAN_W'((base + bs * i) >> 4)] =
                            {1'b1, GRAN_W'((base + bs * (i + 1)) >> 4)};
                    end
                    granule_link[GRAN_W'((base + bs * (count - 1)) >> 4)] = '0;
                    if (count > 1) begin
                        free_head[cls] = {1'b1, ADDR_W'(base + bs)};
                    end else begin
                        free_head[cls] = '0;
                    end
                    carved_chunks++;
                    rsp.grant_addr = ADDR_W'(base);
                    rsp.status     = ST_OK;
                end
            end
            default: begin
                rsp.status = ST_IGNORED;
            end
        endcase
        return rsp;
    endfunction

    function automatic sba_req_t make_req(input func_t f, input int size, input int addr,
                                          input bit av);
        sba_req_t r;
        r.func       = f;
        r.req_size   = SIZE_W'(size);
        r.block_addr = ADDR_W'(addr);
        r.addr_valid = av;
        return r;
    endfunction

    function automatic stim_row_t make_row(input func_t f, input int size, input int addr,
                                           input bit av, input bit typed, input int gaddr,
                                           input status_t st);
        stim_row_t row;
        row.req            = make_req(f, size, addr, av);
        row.typed          = typed;
        row.rsp.grant_addr = ADDR_W'(gaddr);
        row.rsp.status     = st;
        return row;
    endfunction

    // Allocation sizes: mostly legal, with class edges, zero and oversize mixed in.
    function automatic int pick_alloc_size();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 80) begin
            return $urandom_range(1, MAX_BLOCK);
        end else if (k < 88) begin
            return CLASS_BYTES[$urandom_range(0, NUM_CLASSES - 1)] + $urandom_range(0, 1);
        end else if (k < 93) begin
            return 0;
        end
        return $urandom_range(MAX_BLOCK + 1, (1 << SIZE_W) - 1);
    endfunction

    // Random transactions. Most frees hand back a block that is really held, with a size of
    // its own class, so that the lists grow and shrink; the rest are foreign, null, empty or
    // oversize frees. Unused fields carry noise.
    function automatic sba_req_t next_random_request();
        sba_req_t    r;
        held_block_t blk;
        int unsigned pick;
        int unsigned k;
        int          idx;
        int          lo;
        r.func       = FUNC_ALLOC;
        r.req_size   = SIZE_W'($urandom);
        r.block_addr = ADDR_W'($urandom);
        r.addr_valid = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            r.func = FUNC_CLEAR;
        end else if (pick < 4) begin
            r.func = FUNC_RSVD;
        end else if (pick < 50 && held_blocks.size() < 80) begin
            r.func     = FUNC_ALLOC;
            r.req_size = SIZE_W'(pick_alloc_size());
        end else begin
            r.func = FUNC_FREE;
            k = $urandom_range(0, 99);
            if (k < 75 && held_blocks.size() > 0) begin
                idx = $urandom_range(0, held_blocks.size() - 1);
                blk = held_blocks[idx];
                held_blocks.delete(idx);
                lo = (blk.cls == 0) ? 1 : CLASS_BYTES[blk.cls - 1] + 1;
                r.req_size   = SIZE_W'($urandom_range(lo, CLASS_BYTES[blk.cls]));
                r.block_addr = blk.addr;
                // Now and then the low address bits are set; the block drops them.
                if ($urandom_range(0, 7) == 0) begin
                    r.block_addr[3:0] = 4'($urandom);
                end
                r.addr_valid = 1'b1;
            end else if (k < 85) begin
                r.req_size   = SIZE_W'($urandom_range(1, MAX_BLOCK));
                r.addr_valid = 1'b1;
            end else if (k < 90) begin
                r.addr_valid = 1'b0;
            end else if (k < 95) begin
                r.req_size   = '0;
                r.addr_valid = 1'b1;
            end else begin
                r.req_size   = SIZE_W'($urandom_range(MAX_BLOCK + 1, (1 << SIZE_W) - 1));
                r.addr_valid = 1'b1;
            end
        end
        return r;
    endfunction

    // Offers one transaction after a random gap, waits for it to be taken, then records what
    // the block must answer. Valid is only ever lowered or raised once per falling edge.
    task automatic send_request(input sba_req_t r, input bit typed, input sba_rsp_t typed_rsp);
        int          gap;
        sba_rsp_t    got;
        held_block_t blk;
        if (quiet_left > 0) begin
            gap = 0;
            quiet_left--;
        end else if ($urandom_range(0, 15) == 0) begin
            quiet_left = $urandom_range(10, 40);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 19);
        end
        repeat (gap) @(negedge aclk) s_valid <= 1'b0;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
        got = serve_request(r);
        due_rsp.push_back(typed ? typed_rsp : got);
        if (r.func == FUNC_CLEAR) begin
            held_blocks.delete();
        end else if (r.func == FUNC_ALLOC && got.status == ST_OK) begin
            blk.addr = got.grant_addr;
            blk.cls  = class_of(r.req_size);
            held_blocks.push_back(blk);
        end
    endtask

    task automatic send_checked(input sba_req_t r);
        sba_rsp_t none;
        none = '0;
        send_request(r, 1'b0, none);
    endtask

    // Uses up all 64 chunks with few transactions. Each chunk is carved for 640-byte blocks;
    // the second block of the carve is then freed into the empty 16-byte list, which
    // overwrites its link with an end marker. Popping it from both lists leaves both empty,
    // so the next 640-byte request has to carve again.
    task automatic exhaust_pool();
        int unsigned second;
        send_checked(make_req(FUNC_CLEAR, 0, 0, 1'b0));
        for (int k = 0; k < NUM_CHUNKS; k++) begin
            second = k * CHUNK_BYTES + MAX_BLOCK;
            send_checked(make_req(FUNC_ALLOC, MAX_BLOCK, 0, 1'b0));
            send_checked(make_req(FUNC_FREE, CLASS_BYTES[0], second, 1'b1));
            send_checked(make_req(FUNC_ALLOC, CLASS_BYTES[0], 0, 1'b0));
            send_checked(make_req(FUNC_ALLOC, MAX_BLOCK, 0, 1'b0));
        end
        // Every list is empty and no chunk is left, so these run out of memory.
        send_checked(make_req(FUNC_ALLOC, MAX_BLOCK, 0, 1'b0));
        send_checked(make_req(FUNC_ALLOC, 1, 0, 1'b0));
        send_checked(make_req(FUNC_ALLOC, 300, 0, 1'b1));
        // A block handed back can still be served with the pool exhausted.
        send_checked(make_req(FUNC_FREE, 600, MAX_BLOCK, 1'b1));
        send_checked(make_req(FUNC_ALLOC, 600, 0, 1'b0));
        send_checked(make_req(FUNC_CLEAR, 0, 0, 1'b0));
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, due_rsp.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: waits a random number of cycles before each result, sometimes none for a
    // while, and once holds m_ready low for a long stretch so that the result register fills
    // and the block stops taking transactions.
    initial begin
        int stall;
        int quiet;
        m_ready = 1'b0;
        quiet   = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk) m_ready <= 1'b0;
            end
            if (quiet > 0) begin
                stall = 0;
                quiet--;
            end else if ($urandom_range(0, 15) == 0) begin
                quiet = $urandom_range(10, 40);
                stall = 0;
            end else begin
                stall = $urandom_range(0, 19);
            end
            repeat (stall) @(negedge aclk) m_ready <= 1'b0;
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Scoreboard: every result taken must match the oldest expectation, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_rsp.size() == 0) begin
                report_mismatch($sformatf("no result expected, got addr %05h status %0d",
                                          m_rsp.grant_addr, m_rsp.status));
            end else begin
                rsp_want = due_rsp.pop_front();
                if (m_rsp.grant_addr !== rsp_want.grant_addr) begin
                    report_mismatch($sformatf("grant_addr %05h, expected %05h",
                                              m_rsp.grant_addr, rsp_want.grant_addr));
                end
                if (m_rsp.status !== rsp_want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_rsp.status, rsp_want.status));
                end
            end
            rsp_count <= rsp_count + 1;
        end
    end

    // Sender and run control.
    initial begin
        s_valid = 1'b0;
        s_req   = '0;
        aresetn = 1'b0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            free_head[c] = '0;
        end
        for (int g = 0; g < (1 << GRAN_W); g++) begin
            granule_link[g] = '0;
        end
        carved_chunks = 0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table. Right after reset the first carve of each class takes the next
        // chunk in order, so those grants are plain multiples of the chunk size.
        directed_rows.push_back(make_row(FUNC_ALLOC, 16, 'h3_0000, 1'b1, 1'b1, 0, ST_OK));
        directed_rows.push_back(make_row(FUNC_ALLOC, 17, 0, 1'b0, 1'b1, CHUNK_BYTES, ST_OK));
        directed_rows.push_back(make_row(FUNC_ALLOC, MAX_BLOCK, 0, 1'b0, 1'b1,
                                         2 * CHUNK_BYTES, ST_OK));
        directed_rows.push_back(make_row(FUNC_ALLOC, MAX_BLOCK + 1, 0, 1'b0, 1'b1, 0,
                                         ST_TOO_LARGE));
        directed_rows.push_back(make_row(FUNC_ALLOC, 4095, 'hF_FFFF, 1'b1, 1'b1, 0,
                                         ST_TOO_LARGE));
        directed_rows.push_back(make_row(FUNC_ALLOC, 0, 0, 1'b0, 1'b1, 0, ST_IGNORED));
        // Zero-size free, then a null free whose oversize must not matter.
        directed_rows.push_back(make_row(FUNC_FREE, 0, 'h0_0040, 1'b1, 1'b1, 0, ST_IGNORED));
        directed_rows.push_back(make_row(FUNC_FREE, 4095, 'h0_0040, 1'b0, 1'b1, 0,
                                         ST_IGNORED));
        directed_rows.push_back(make_row(FUNC_FREE, MAX_BLOCK + 1, 'h0_0040, 1'b1, 1'b1, 0,
                                         ST_TOO_LARGE));
        directed_rows.push_back(make_row(FUNC_ALLOC, 1, 0, 1'b0, 1'b1, 16, ST_OK));
        // Free and reallocate: the list is last in, first out.
        directed_rows.push_back(make_row(FUNC_FREE, 16, 0, 1'b1, 1'b0, 0, ST_OK));
        directed_rows.push_back(make_row(FUNC_ALLOC, 16, 0, 1'b0, 1'b1, 0, ST_OK));
        // An unaligned foreign address at the top of the space loses its low bits.
        directed_rows.push_back(make_row(FUNC_FREE, MAX_BLOCK, 'hF_FFFF, 1'b1, 1'b0, 0,
                                         ST_OK));
        directed_rows.push_back(make_row(FUNC_ALLOC, 513, 0, 1'b0, 1'b1, 'hF_FFF0, ST_OK));
        directed_rows.push_back(make_row(FUNC_ALLOC, 512, 0, 1'b0, 1'b1, 3 * CHUNK_BYTES,
                                         ST_OK));
        directed_rows.push_back(make_row(FUNC_RSVD, 4095, 'hF_FFFF, 1'b1, 1'b1, 0,
                                         ST_IGNORED));
        directed_rows.push_back(make_row(FUNC_FREE, 1, 'h1_2345, 1'b1, 1'b0, 0, ST_OK));
        directed_rows.push_back(make_row(FUNC_ALLOC, 16, 0, 1'b0, 1'b0, 0, ST_OK));
        directed_rows.push_back(make_row(FUNC_ALLOC, 448, 0, 1'b0, 1'b0, 0, ST_OK));
        directed_rows.push_back(make_row(FUNC_ALLOC, 96, 0, 1'b0, 1'b0, 0, ST_OK));
        directed_rows.push_back(make_row(FUNC_ALLOC, 97, 0, 1'b0, 1'b0, 0, ST_OK));
        directed_rows.push_back(make_row(FUNC_CLEAR, 4095, 'hF_FFFF, 1'b1, 1'b1, 0, ST_OK));
        // After a clear the pool starts again from chunk zero.
        directed_rows.push_back(make_row(FUNC_ALLOC, MAX_BLOCK, 0, 1'b0, 1'b1, 0, ST_OK));
        directed_rows.push_back(make_row(FUNC_ALLOC, 600, 0, 1'b0, 1'b0, 0, ST_OK));
        directed_rows.push_back(make_row(FUNC_FREE, MAX_BLOCK, 0, 1'b0, 1'b1, 0,
                                         ST_IGNORED));
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
        end

        exhaust_pool();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Partway through, the receiver stops for a long time while the sender keeps
            // offering transactions back to back.
            if (n == 300) begin
                hold_off_req = 1'b1;
                quiet_left   = 60;
            end
            send_checked(next_random_request());
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_rsp.size() != 0) begin
            @(posedge aclk);
        end
        // A stray extra result would show up during this wait.
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
